### rtl/sat_pkg.sv
// Shared types, register indexes and constants for the steering aligning torque block.
`default_nettype none

package sat_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ALPHA = 3'd0,
        REG_MAX_STEER    = 3'd1,
        REG_AIR_THRESH   = 3'd2,
        REG_LOAD_FLOOR   = 3'd3,
        REG_LOAD_CEIL    = 3'd4
    } cfg_reg_t;

    // Register reset values.
    localparam logic [15:0] ALPHA_RST      = 16'd16384;
    localparam logic [15:0] MAX_STEER_RST  = 16'd2753;
    localparam logic [15:0] AIR_THRESH_RST = 16'd10;
    localparam logic [14:0] LOAD_FLOOR_RST = 15'd1638;
    localparam logic [14:0] LOAD_CEIL_RST  = 15'd19661;

    // Digit-serial multiplier geometry: a 17 bit parallel operand times a
    // serial operand of up to 48 bits, consumed 4 bits per cycle.
    localparam int MUL_B_W   = 17;
    localparam int MUL_S_W   = 48;
    localparam int MUL_DIG_W = 4;
    localparam int MUL_HI_W  = 18;
    localparam int MUL_CNT_W = 4;

    localparam logic [MUL_CNT_W-1:0] MUL_STEPS_SHORT = 4'd4;
    localparam logic [MUL_CNT_W-1:0] MUL_STEPS_MID   = 4'd8;
    localparam logic [MUL_CNT_W-1:0] MUL_STEPS_LONG  = 4'd12;

    // Bit-serial divider geometry: a left-aligned 29 bit dividend and a
    // constant divisor below 1024.
    localparam int DIV_N_W   = 29;
    localparam int DIV_D_W   = 10;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LOAD = 5'd29;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FADE = 5'd20;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_COS  = 5'd16;

    // Divisors: 16384/20000 reduces to 512/625, 65536/960 to 1024/15.
    localparam logic [DIV_D_W-1:0] LOAD_DEN = 10'd625;
    localparam logic [DIV_D_W-1:0] FADE_DEN = 10'd15;
    localparam logic [DIV_D_W-1:0] COS_DEN  = 10'd24;

    // Arithmetic constants.
    localparam logic [15:0] FADE_END   = 16'd960;
    localparam logic [16:0] UNIT_Q16   = 17'h10000;
    localparam logic [17:0] COS_ONE    = 18'd65536;
    localparam logic [32:0] RND_UP     = 33'd32768;
    localparam logic [32:0] RND_DOWN   = 33'd32767;
    localparam logic [16:0] TORQUE_MAX = 17'd32767;

    // Input and result words.
    typedef struct packed {
        logic signed [15:0] steering;
        logic signed [15:0] lateral_accel;
        logic [15:0]        speed;
        logic signed [19:0] front_left_force;
        logic signed [19:0] front_right_force;
    } sat_in_t;

    typedef struct packed {
        logic signed [15:0] torque;
        logic signed [15:0] smoothed_accel;
    } sat_out_t;

    // Launch controls for the serial units.
    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] steps;
    } mul_ctl_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctl_t;

    // Sequencer states, one per arithmetic pass.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILTER,
        ST_ANGLE,
        ST_SQUARE,
        ST_QUART,
        ST_COSDIV,
        ST_PROD1,
        ST_PROD2,
        ST_PROD3
    } sat_state_t;

endpackage

`default_nettype wire

### rtl/sat_mul.sv
// Digit-serial multiplier: parallel operand times a serial operand, 4 bits per cycle.
`default_nettype none

module sat_mul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sat_pkg::mul_ctl_t                ctl,
    input  logic [sat_pkg::MUL_B_W-1:0]      mcand,
    input  logic [sat_pkg::MUL_S_W-1:0]      mplier,
    output logic                             busy,
    output logic [sat_pkg::MUL_HI_W-1:0]     prod_hi,
    output logic [sat_pkg::MUL_S_W-1:0]      prod_lo
);
    import sat_pkg::*;

    logic [MUL_B_W-1:0]            b_reg;
    logic [MUL_S_W-1:0]            ser_reg;
    logic [MUL_S_W-1:0]            ser_next;
    logic [MUL_HI_W-1:0]           acc_reg;
    logic [MUL_HI_W-1:0]           acc_next;
    logic [MUL_S_W-1:0]            lo_reg;
    logic [MUL_S_W-1:0]            lo_next;
    logic [MUL_CNT_W-1:0]          cnt_reg;
    logic [MUL_CNT_W-1:0]          cnt_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic [MUL_B_W+MUL_DIG_W-1:0]  partial;
    logic [MUL_HI_W+MUL_DIG_W-1:0] step_sum;

    // One digit step: add the partial product to the running high part and
    // shift the finished low digit into the product register from the top.
    assign partial  = {{MUL_DIG_W{1'b0}}, b_reg}
                    * {{MUL_B_W{1'b0}}, ser_reg[MUL_DIG_W-1:0]};
    assign step_sum = {{MUL_DIG_W{1'b0}}, acc_reg} + {1'b0, partial};

    always_comb begin
        ser_next = {{MUL_DIG_W{1'b0}}, ser_reg[MUL_S_W-1:MUL_DIG_W]};
        acc_next = step_sum[MUL_HI_W+MUL_DIG_W-1:MUL_DIG_W];
        lo_next  = {step_sum[MUL_DIG_W-1:0], lo_reg[MUL_S_W-1:MUL_DIG_W]};
        cnt_next = cnt_reg - 1'b1;
        busy_next = (cnt_reg != {{(MUL_CNT_W-1){1'b0}}, 1'b1});
    end

    // Operand and product registers.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            b_reg   <= mcand;
            ser_reg <= mplier;
            acc_reg <= '0;
            lo_reg  <= '0;
        end else if (busy_reg) begin
            ser_reg <= ser_next;
            acc_reg <= acc_next;
            lo_reg  <= lo_next;
        end
    end

    // Step counter and busy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else if (ctl.start) begin
            cnt_reg  <= ctl.steps;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy    = busy_reg;
    assign prod_hi = acc_reg;
    assign prod_lo = lo_reg;

endmodule

`default_nettype wire

### rtl/sat_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, dividend MSB first.
`default_nettype none

module sat_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  sat_pkg::div_ctl_t                ctl,
    input  logic [sat_pkg::DIV_N_W-1:0]      dividend,
    input  logic [sat_pkg::DIV_D_W-1:0]      divisor,
    output logic                             busy,
    output logic [sat_pkg::DIV_N_W-1:0]      quotient
);
    import sat_pkg::*;

    logic [DIV_N_W-1:0]   num_reg;
    logic [DIV_N_W-1:0]   num_next;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_N_W-1:0]   quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        trial     = {rem_reg, num_reg[DIV_N_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        quo_next  = {quo_reg[DIV_N_W-2:0], fits};
        num_next  = {num_reg[DIV_N_W-2:0], 1'b0};
        cnt_next  = cnt_reg - 1'b1;
        busy_next = (cnt_reg != {{(DIV_CNT_W-1){1'b0}}, 1'b1});
    end

    // Dividend, remainder and quotient registers.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Step counter and busy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else if (ctl.start) begin
            cnt_reg  <= ctl.steps;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/steering_aligning_torque.sv
// Top level of the steering aligning torque estimator.
//
//   Channel  Ports                          Word
//   input    s_valid, s_ready, s_data       sat_in_t: steering, lateral_accel, speed, forces
//   result   m_valid, m_ready, m_data       sat_out_t: torque, smoothed_accel
//   config   cfg_wr_en, cfg_index, cfg_wdata  one register write per enabled cycle
//
// One word is processed at a time, and a new word is taken only once the
// previous result has been loaded into the output register. The time per
// word is set by the shared 4 bit digit-serial multiplier (seven
// passes, 40 digit steps) and the bit-serial divide by 24 in the cosine.
// The load and fade divisions run on their own dividers alongside the
// multiplier. Reset is synchronous, active low, and restores the register
// defaults and a zero filter state. A stalled result waits in the output
// register while the next word is already accepted and processed.
`default_nettype none

module steering_aligning_torque (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sat_pkg::sat_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sat_pkg::sat_out_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [sat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sat_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sat_pkg::*;

    // Configuration registers.
    logic [15:0] alpha_reg;
    logic [15:0] max_steer_reg;
    logic [15:0] air_thresh_reg;
    logic [14:0] floor_reg;
    logic [14:0] ceil_reg;

    // Sequencer.
    sat_state_t state_reg;
    sat_state_t state_next;
    logic       advance;
    logic       s_accept;

    // Per-word registers.
    logic [15:0] fs_reg;
    logic [15:0] amag_reg;
    logic        dneg_reg;
    logic        airborne_reg;
    logic        slow_reg;
    logic [15:0] x2_reg;
    logic        m_valid_reg;
    sat_out_t    m_data_reg;

    // Serial unit connections.
    mul_ctl_t              mul_ctl;
    logic [MUL_B_W-1:0]    mul_mcand;
    logic [MUL_S_W-1:0]    mul_mplier;
    logic                  mul_busy;
    logic [MUL_HI_W-1:0]   mul_hi;
    logic [MUL_S_W-1:0]    mul_lo;
    div_ctl_t              ld_ctl;
    div_ctl_t              fd_ctl;
    div_ctl_t              cd_ctl;
    logic                  ld_busy;
    logic                  fd_busy;
    logic                  cd_busy;
    logic [DIV_N_W-1:0]    ld_quo;
    logic [DIV_N_W-1:0]    fd_quo;
    logic [DIV_N_W-1:0]    cd_quo;
    logic [DIV_N_W-1:0]    ld_dividend;
    logic [DIV_N_W-1:0]    fd_dividend;
    logic [DIV_N_W-1:0]    cd_dividend;

    // Datapath terms.
    logic [16:0] lat_diff;
    logic [16:0] diff_mag_w;
    logic [15:0] diff_mag;
    logic [15:0] steer_mag;
    logic [20:0] force_sum;
    logic        airborne;
    logic        slow;
    logic [31:0] prod_mid;
    logic [45:0] prod_wide;
    logic [32:0] round_sum;
    logic [15:0] delta;
    logic [17:0] sway_ext;
    logic [15:0] sway_new;
    logic [15:0] angle_x;
    logic [15:0] power_q16;
    logic [17:0] cos_ext;
    logic [16:0] cos_val;
    logic [15:0] sway_mag;
    logic [14:0] load_top;
    logic [14:0] load_val;
    logic [16:0] fade_val;
    logic [16:0] rounded;
    logic [14:0] torque_mag;
    logic [15:0] torque_val;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg      <= ALPHA_RST;
            max_steer_reg  <= MAX_STEER_RST;
            air_thresh_reg <= AIR_THRESH_RST;
            floor_reg      <= LOAD_FLOOR_RST;
            ceil_reg       <= LOAD_CEIL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FILTER_ALPHA: alpha_reg      <= cfg_wdata;
                REG_MAX_STEER:    max_steer_reg  <= cfg_wdata;
                REG_AIR_THRESH:   air_thresh_reg <= cfg_wdata;
                REG_LOAD_FLOOR:   floor_reg      <= cfg_wdata[14:0];
                REG_LOAD_CEIL:    ceil_reg       <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Terms taken from the incoming word at acceptance.
    always_comb begin
        lat_diff   = {s_data.lateral_accel[15], s_data.lateral_accel}
                   - {fs_reg[15], fs_reg};
        diff_mag_w = lat_diff[16] ? (17'd0 - lat_diff) : lat_diff;
        diff_mag   = diff_mag_w[15:0];
        steer_mag  = s_data.steering[15] ? (16'd0 - s_data.steering) : s_data.steering;
        force_sum  = {s_data.front_left_force[19], s_data.front_left_force}
                   + {s_data.front_right_force[19], s_data.front_right_force};
        airborne   = ($signed(force_sum) <= $signed({5'b0, air_thresh_reg}));
        slow       = (s_data.speed < FADE_END);
        ld_dividend = {force_sum[19:0], 9'b0};
        fd_dividend = {s_data.speed[9:0], 19'b0};
    end

    // Filter update: the delta is alpha times the difference, rounded to
    // nearest with ties toward plus infinity, applied by magnitude and sign.
    always_comb begin
        prod_mid  = {mul_hi[15:0], mul_lo[47:32]};
        round_sum = {1'b0, prod_mid} + (dneg_reg ? RND_DOWN : RND_UP);
        delta     = round_sum[31:16];
        sway_ext  = {{2{fs_reg[15]}}, fs_reg}
                  + (dneg_reg ? (18'd0 - {2'b0, delta}) : {2'b0, delta});
        sway_new  = sway_ext[15:0];
    end

    // Angle, its powers and the cosine series.
    always_comb begin
        angle_x     = {mul_hi[14:0], mul_lo[47]};
        power_q16   = mul_hi[15:0];
        cos_dividend_build();
        cos_ext     = COS_ONE - {3'b0, x2_reg[15:1]} + {2'b0, cd_quo[15:0]};
        cos_val     = cos_ext[16:0];
        sway_mag    = fs_reg[15] ? (16'd0 - fs_reg) : fs_reg;
    end

    function automatic void cos_dividend_build();
    endfunction

    assign cd_dividend = {mul_hi[15:0], 13'b0};

    // Load factor clamp and speed fade.
    always_comb begin
        load_top = (ld_quo > {14'b0, ceil_reg}) ? ceil_reg : ld_quo[14:0];
        if (airborne_reg) begin
            load_val = floor_reg;
        end else begin
            load_val = (load_top < floor_reg) ? floor_reg : load_top;
        end
        fade_val = slow_reg ? {1'b0, fd_quo[15:0]} : UNIT_Q16;
    end

    // Final rounding, saturation and sign of the torque.
    always_comb begin
        prod_wide  = {mul_hi[13:0], mul_lo[47:16]};
        rounded    = {1'b0, mul_hi[13:0], mul_lo[47:46]} + {16'b0, mul_lo[45]};
        torque_mag = (rounded > TORQUE_MAX) ? TORQUE_MAX[14:0] : rounded[14:0];
        torque_val = fs_reg[15] ? (16'd0 - {1'b0, torque_mag}) : {1'b0, torque_mag};
    end

    // Sequencer outputs: when a pass ends, the next one is launched.
    always_comb begin
        advance     = 1'b0;
        mul_ctl     = '0;
        mul_mcand   = '0;
        mul_mplier  = '0;
        ld_ctl      = '0;
        fd_ctl      = '0;
        cd_ctl      = '0;
        ld_ctl.steps = DIV_STEPS_LOAD;
        fd_ctl.steps = DIV_STEPS_FADE;
        cd_ctl.steps = DIV_STEPS_COS;
        case (state_reg)
            ST_IDLE: begin
                advance       = s_accept;
                mul_ctl.start = s_accept;
                mul_ctl.steps = MUL_STEPS_SHORT;
                mul_mcand     = {1'b0, diff_mag};
                mul_mplier    = {32'b0, alpha_reg};
                ld_ctl.start  = s_accept;
                fd_ctl.start  = s_accept;
            end
            ST_FILTER: begin
                advance       = !mul_busy;
                mul_ctl.start = !mul_busy;
                mul_ctl.steps = MUL_STEPS_SHORT;
                mul_mcand     = {1'b0, max_steer_reg};
                mul_mplier    = {32'b0, amag_reg};
            end
            ST_ANGLE: begin
                advance       = !mul_busy;
                mul_ctl.start = !mul_busy;
                mul_ctl.steps = MUL_STEPS_SHORT;
                mul_mcand     = {1'b0, angle_x};
                mul_mplier    = {32'b0, angle_x};
            end
            ST_SQUARE: begin
                advance       = !mul_busy;
                mul_ctl.start = !mul_busy;
                mul_ctl.steps = MUL_STEPS_SHORT;
                mul_mcand     = {1'b0, power_q16};
                mul_mplier    = {32'b0, power_q16};
            end
            ST_QUART: begin
                advance      = !mul_busy;
                cd_ctl.start = !mul_busy;
            end
            ST_COSDIV: begin
                advance       = !cd_busy;
                mul_ctl.start = !cd_busy;
                mul_ctl.steps = MUL_STEPS_SHORT;
                mul_mcand     = cos_val;
                mul_mplier    = {32'b0, sway_mag};
            end
            ST_PROD1: begin
                advance       = !mul_busy && !ld_busy;
                mul_ctl.start = !mul_busy && !ld_busy;
                mul_ctl.steps = MUL_STEPS_MID;
                mul_mcand     = {2'b0, load_val};
                mul_mplier    = {16'b0, prod_mid};
            end
            ST_PROD2: begin
                advance       = !mul_busy && !fd_busy;
                mul_ctl.start = !mul_busy && !fd_busy;
                mul_ctl.steps = MUL_STEPS_LONG;
                mul_mcand     = fade_val;
                mul_mplier    = {2'b0, prod_wide};
            end
            ST_PROD3: begin
                advance = !mul_busy && (!m_valid_reg || m_ready);
            end
            default: ;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (advance) state_next = ST_FILTER;
            ST_FILTER: if (advance) state_next = ST_ANGLE;
            ST_ANGLE:  if (advance) state_next = ST_SQUARE;
            ST_SQUARE: if (advance) state_next = ST_QUART;
            ST_QUART:  if (advance) state_next = ST_COSDIV;
            ST_COSDIV: if (advance) state_next = ST_PROD1;
            ST_PROD1:  if (advance) state_next = ST_PROD2;
            ST_PROD2:  if (advance) state_next = ST_PROD3;
            ST_PROD3:  if (advance) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state: sequencer, filter state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fs_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FILTER && advance) begin
                fs_reg <= sway_new;
            end
            if (state_reg == ST_PROD3 && advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Per-word payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && advance) begin
            amag_reg     <= steer_mag;
            dneg_reg     <= lat_diff[16];
            airborne_reg <= airborne;
            slow_reg     <= slow;
        end
        if (state_reg == ST_SQUARE && advance) begin
            x2_reg <= power_q16;
        end
        if (state_reg == ST_PROD3 && advance) begin
            m_data_reg.torque         <= torque_val;
            m_data_reg.smoothed_accel <= fs_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Shared multiplier and the three dividers.
    sat_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .busy    (mul_busy),
        .prod_hi (mul_hi),
        .prod_lo (mul_lo)
    );

    sat_div u_load_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ld_ctl),
        .dividend (ld_dividend),
        .divisor  (LOAD_DEN),
        .busy     (ld_busy),
        .quotient (ld_quo)
    );

    sat_div u_fade_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (fd_ctl),
        .dividend (fd_dividend),
        .divisor  (FADE_DEN),
        .busy     (fd_busy),
        .quotient (fd_quo)
    );

    sat_div u_cos_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (cd_ctl),
        .dividend (cd_dividend),
        .divisor  (COS_DEN),
        .busy     (cd_busy),
        .quotient (cd_quo)
    );

endmodule

`default_nettype wire

### dv/sat_checker.sv
// Checker for the steering aligning torque block: predicts every result and compares it.
module sat_checker
    import sat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  sat_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  sat_out_t              m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding,
    output int                    samples,
    output int                    results
);

    localparam longint     ONE_Q16    = 64'sd65536;
    localparam longint     HALF_Q16   = 64'sd32768;
    localparam bit [63:0]  FADE_KPH   = 64'd960;
    localparam longint     LOAD_SCALE = 64'sd16384;
    localparam longint     LOAD_NORM  = 64'sd20000;
    localparam bit [63:0]  TORQUE_LIM = 64'd32767;

    // Shadow copies of the registers and of the filter state.
    logic [15:0]        alpha_q16;
    logic [15:0]        steer_max;
    logic [15:0]        air_thresh;
    logic [14:0]        load_min;
    logic [14:0]        load_max;
    logic signed [15:0] sway;

    // Results still owed by the block, oldest first.
    sat_out_t pending_results[$];

    // Works out the result word for one sample, given the filter state before it.
    function automatic sat_out_t estimate_torque(input sat_in_t w,
                                                 input logic signed [15:0] prev);
        longint    blend;
        longint    smoothed;
        longint    steer;
        longint    force_sum;
        bit [63:0] steer_mag;
        bit [63:0] angle;
        bit [63:0] sq;
        bit [63:0] quad;
        bit [63:0] cosine;
        bit [63:0] load;
        bit [63:0] fade;
        bit [63:0] accel_mag;
        bit [63:0] prod;
        bit [63:0] mag;
        sat_out_t  r;

        // First-order low-pass, rounded to nearest with ties toward plus infinity.
        blend = longint'(alpha_q16) * longint'(w.lateral_accel)
              + (ONE_Q16 - longint'(alpha_q16)) * longint'(prev) + HALF_Q16;
        smoothed = blend >>> 16;

        // Road-wheel angle and the truncated cosine series.
        steer = longint'(w.steering);
        steer_mag = (steer < 0) ? -steer : steer;
        angle = (steer_mag * steer_max) >> 15;
        sq = (angle * angle) >> 16;
        quad = (sq * sq) >> 16;
        cosine = 64'd65536 - (sq >> 1) + quad / 24;

        // Front load factor; a light or negative sum takes the floor.
        force_sum = longint'(w.front_left_force) + longint'(w.front_right_force);
        if (force_sum <= longint'(air_thresh)) begin
            load = load_min;
        end else begin
            load = (force_sum * LOAD_SCALE) / LOAD_NORM;
            if (load > load_max) begin
                load = load_max;
            end
            if (load < load_min) begin
                load = load_min;
            end
        end

        // Low-speed fade.
        fade = w.speed;
        if (fade < FADE_KPH) begin
            fade = (fade << 16) / FADE_KPH;
        end else begin
            fade = 64'd65536;
        end

        // Product rounded half away from zero, then saturated and signed.
        accel_mag = (smoothed < 0) ? -smoothed : smoothed;
        prod = accel_mag * cosine * load * fade;
        mag = (prod + (64'd1 << 45)) >> 46;
        if (mag > TORQUE_LIM) begin
            mag = TORQUE_LIM;
        end
        r.smoothed_accel = smoothed[15:0];
        r.torque = (smoothed < 0) ? 16'(64'd0 - mag) : 16'(mag);
        return r;
    endfunction

    // Follow register writes, predict on each accepted sample, compare each result.
    always @(posedge aclk) begin : watch
        sat_out_t predicted;
        sat_out_t oldest;
        int       bad;
        bad = 0;
        if (!aresetn) begin
            alpha_q16 <= ALPHA_RST;
            steer_max <= MAX_STEER_RST;
            air_thresh <= AIR_THRESH_RST;
            load_min <= LOAD_FLOOR_RST;
            load_max <= LOAD_CEIL_RST;
            sway <= '0;
            pending_results.delete();
            mismatches <= 0;
            outstanding <= 0;
            samples <= 0;
            results <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FILTER_ALPHA: alpha_q16 <= cfg_wdata;
                    REG_MAX_STEER:    steer_max <= cfg_wdata;
                    REG_AIR_THRESH:   air_thresh <= cfg_wdata;
                    REG_LOAD_FLOOR:   load_min <= cfg_wdata[14:0];
                    REG_LOAD_CEIL:    load_max <= cfg_wdata[14:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                predicted = estimate_torque(s_data, sway);
                sway <= predicted.smoothed_accel;
                pending_results.push_back(predicted);
                samples <= samples + 1;
            end

            if (m_valid && m_ready) begin
                results <= results + 1;
                if (pending_results.size() == 0) begin
                    $error("result with no sample pending: torque %0d, smoothed_accel %0d",
                           m_data.torque, m_data.smoothed_accel);
                    bad++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (m_data.torque !== oldest.torque) begin
                        $error("torque mismatch: expected %0d, actual %0d",
                               oldest.torque, m_data.torque);
                        bad++;
                    end
                    if (m_data.smoothed_accel !== oldest.smoothed_accel) begin
                        $error("smoothed_accel mismatch: expected %0d, actual %0d",
                               oldest.smoothed_accel, m_data.smoothed_accel);
                        bad++;
                    end
                end
            end

            mismatches <= mismatches + bad;
            outstanding <= pending_results.size();
        end
    end

endmodule

### dv/tb.sv
// Testbench top for the steering aligning torque block: stimulus, flow control and verdict.
module tb;

    import sat_pkg::*;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_SAMPLES  = 100;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_AT        = 250;
    localparam int HOLD_CYCLES    = 500;
    localparam int TIMEOUT_CYCLES = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sat_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    sat_out_t              m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int samples_seen;
    int results_seen;

    int          sent;
    int          taken;
    int          settings;
    logic [15:0] air_thresh_now;

    steering_aligning_torque dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sat_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .samples     (samples_seen),
        .results     (results_seen)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Returns one end of the range or a value in between.
    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Random sample; force sums are steered toward the threshold and the load range.
    function automatic sat_in_t random_sample();
        sat_in_t w;
        int      fl;
        int      fr;
        case ($urandom_range(0, 7))
            0:       w.steering = 16'sh8000;
            1:       w.steering = 16'sh7fff;
            2:       w.steering = '0;
            default: w.steering = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       w.lateral_accel = 16'sh8000;
            1:       w.lateral_accel = 16'sh7fff;
            default: w.lateral_accel = 16'($urandom);
        endcase
        w.speed = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1100)) : 16'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                fl = $urandom;
                fr = $urandom;
            end
            1: begin
                fl = int'($urandom_range(0, 30000)) - 6000;
                fr = int'($urandom_range(0, 30000)) - 6000;
            end
            2: begin
                fr = int'($urandom_range(0, 2000)) - 1000;
                fl = int'(air_thresh_now) + int'($urandom_range(0, 4)) - 2 - fr;
            end
            default: begin
                fl = $urandom_range(0, 1) ? -524288 : 524287;
                fr = $urandom_range(0, 1) ? -524288 : 524287;
            end
        endcase
        w.front_left_force = 20'(fl);
        w.front_right_force = 20'(fr);
        return w;
    endfunction

    // Offer one word after a random gap and hold it until it is taken.
    task automatic offer(input sat_in_t w);
        int gap;
        gap = ((sent / 32) % 3 == 1) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic directed(input int st, input int lat, input int spd,
                            input int fl, input int fr);
        sat_in_t w;
        w.steering = 16'(st);
        w.lateral_accel = 16'(lat);
        w.speed = 16'(spd);
        w.front_left_force = 20'(fl);
        w.front_right_force = 20'(fr);
        offer(w);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [15:0] alpha, input logic [15:0] steer,
                                 input logic [15:0] thresh, input logic [15:0] floor_q14,
                                 input logic [15:0] ceil_q14);
        write_reg(REG_FILTER_ALPHA, alpha);
        write_reg(REG_MAX_STEER, steer);
        write_reg(REG_AIR_THRESH, thresh);
        write_reg(REG_LOAD_FLOOR, floor_q14);
        write_reg(REG_LOAD_CEIL, ceil_q14);
        cfg_wr_en <= 1'b0;
        air_thresh_now = thresh;
        settings++;
    endtask

    // Result side: random stalls, quiet stretches and one long hold-off.
    initial begin : sink
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = ((taken / 32) % 3 == 2) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Main sequence: reset, directed samples, then random phases under new settings.
    initial begin : source
        sent = 0;
        taken = 0;
        settings = 1;
        air_thresh_now = AIR_THRESH_RST;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_FILTER_ALPHA;
        cfg_wdata <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes, the threshold edge, the fade edge and the load range.
        directed(0, 0, 0, 0, 0);
        directed(32767, 32767, 65535, 524287, 524287);
        directed(-32768, -32768, 0, -524288, -524288);
        directed(16384, 1000, 959, 5, 5);
        directed(-16384, -1000, 960, 6, 5);
        directed(8192, 4000, 480, 1000, 500);
        directed(-8192, 4000, 65535, 10000, 10000);
        directed(24576, 4000, 65535, 12000, 12000);
        directed(-24576, 4000, 65535, 12001, 12000);
        // Driving the filter hard both ways saturates the torque.
        repeat (7) directed(0, 32767, 65535, 200000, 200000);
        repeat (9) directed(0, -32768, 65535, 200000, 200000);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: load_settings(16'd65535, 16'd32768, 16'd0, 16'd0, 16'd32767);
                // Alpha of zero freezes the filter; the floor sits above the ceiling.
                1: load_settings(16'd0, 16'd0, 16'd65535, 16'd32767, 16'd0);
                default: load_settings(16'(pick(0, 65535)), 16'(pick(0, 32768)),
                                       16'(pick(0, 65535)),
                                       {1'($urandom_range(0, 1)), 15'(pick(0, 32767))},
                                       {1'($urandom_range(0, 1)), 15'(pick(0, 32767))});
            endcase
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                offer(random_sample());
            end
        end

        settle();
        $display("Run covered %0d samples under %0d register settings; %0d results checked.",
                 samples_seen, settings, results_seen);
        $display("The result side was held off once for %0d cycles with input pending.",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hang guard.
    initial begin : watchdog
        #(TIMEOUT_CYCLES * 10);
        $display("Run stopped after %0d cycles without finishing.", TIMEOUT_CYCLES);
        $display("status: fail");
        $finish;
    end

endmodule
